### rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int ValueWidth = 32;
    localparam int CountFieldWidth = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_EMPTY_ERROR = 2'd1,
        STATUS_FULL_ERROR  = 2'd2
    } status_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic                          insert_en;
        logic                          remove_en;
        logic                          min_mode;
        logic signed [ValueWidth-1:0]  value;
    } cell_ctrl_t;

endpackage

### rtl/spq_cell.sv
// One storage cell of the queue chain: holds one entry and its valid bit.
module spq_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  spq_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [spq_pkg::ValueWidth-1:0] left_entry,
    input  logic                                  left_valid,
    input  logic                                  left_found,
    input  logic signed [spq_pkg::ValueWidth-1:0] right_entry,
    input  logic                                  right_valid,
    output logic signed [spq_pkg::ValueWidth-1:0] entry,
    output logic                                  valid,
    output logic                                  found,
    output logic signed [spq_pkg::ValueWidth-1:0] entry_next,
    output logic                                  valid_next
);

    logic signed [spq_pkg::ValueWidth-1:0] entry_reg;
    logic                                  valid_reg;
    logic                                  hit;

    // An empty cell always hits, so the new value lands there if no cell before it hit; the tail acts as a catch-all.
    assign hit = !valid_reg ||
                 (ctrl.min_mode ? (ctrl.value < entry_reg) : (ctrl.value > entry_reg));
    assign found = left_found | hit;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.insert_en) begin
            if (left_found) begin
                entry_next = left_entry;
                valid_next = left_valid;
            end else if (hit) begin
                entry_next = ctrl.value;
                valid_next = 1'b1;
            end
        end else if (ctrl.remove_en) begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

### rtl/sorted_priority_queue.sv
// Sorted priority queue built as a chain of storage cells.
// Accepts one insert or remove request every clock cycle and returns one registered
// result for each; a result register stalled by the sink holds off requests until
// the sink takes it. All cells update together on an accepted request; the longest
// path is the ripple of the insert-position flag through the CAPACITY cells. Equal
// values leave in arrival order. min_mode (reset 1) puts the smallest value at the
// front; when it is changed with entries held, the entries stay where they are and a
// new value goes before the first entry it strictly precedes under the new mode.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,      // min_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // [31:0] value
    input  logic [0:0]  s_tuser,        // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata         // [31:0] removed_value, [63:32] front_value,
                                        // [64] queue_empty, [69:65] entry_count,
                                        // [71:70] status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = spq_pkg::ValueWidth;

    logic                 min_mode_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    spq_pkg::cell_ctrl_t  ctrl;
    spq_pkg::status_t     status;
    logic                 accept;
    logic                 is_remove;
    logic                 queue_full;

    logic signed [VW-1:0] cell_entry      [CAPACITY];
    logic                 cell_valid      [CAPACITY];
    logic                 cell_found      [CAPACITY];
    logic signed [VW-1:0] cell_entry_next [CAPACITY];
    logic                 cell_valid_next [CAPACITY];
    logic [CAPACITY-1:0]  valid_vec;

    logic                 out_valid_reg;
    logic signed [VW-1:0] removed_reg;
    logic signed [VW-1:0] front_reg;
    logic                 empty_reg;
    logic [spq_pkg::CountFieldWidth-1:0] count_out_reg;
    spq_pkg::status_t     status_reg;
    logic [CW+spq_pkg::CountFieldWidth-1:0] count_wide;

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign is_remove  = (s_tuser[0] == spq_pkg::OP_REMOVE);
    assign queue_full = (count_reg == CW'(CAPACITY));

    always_comb begin
        status = spq_pkg::STATUS_OK;
        if (is_remove && count_reg == '0) begin
            status = spq_pkg::STATUS_EMPTY_ERROR;
        end else if (!is_remove && queue_full) begin
            status = spq_pkg::STATUS_FULL_ERROR;
        end
    end

    always_comb begin
        ctrl.insert_en = accept && !is_remove && (status == spq_pkg::STATUS_OK);
        ctrl.remove_en = accept && is_remove && (status == spq_pkg::STATUS_OK);
        ctrl.min_mode  = min_mode_reg;
        ctrl.value     = $signed(s_tdata);
        count_next     = count_reg;
        if (ctrl.insert_en) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.remove_en) begin
            count_next = count_reg - CW'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VW-1:0] l_entry;
        logic                 l_valid;
        logic                 l_found;
        logic signed [VW-1:0] r_entry;
        logic                 r_valid;

        if (i == 0) begin : g_head
            assign l_entry = ctrl.value;
            assign l_valid = 1'b1;
            assign l_found = 1'b0;
        end else begin : g_body
            assign l_entry = cell_entry[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_found = cell_found[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign r_entry = cell_entry[i];
            assign r_valid = 1'b0;
        end else begin : g_inner
            assign r_entry = cell_entry[i+1];
            assign r_valid = cell_valid[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_found  (l_found),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .found       (cell_found[i]),
            .entry_next  (cell_entry_next[i]),
            .valid_next  (cell_valid_next[i])
        );

        assign valid_vec[i] = cell_valid[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_mode_reg <= 1'b1;
            count_reg    <= '0;
        end else begin
            if (cfg_wen) begin
                min_mode_reg <= cfg_wdata;
            end
            count_reg <= count_next;
        end
    end

    assign count_wide = {{spq_pkg::CountFieldWidth{1'b0}}, count_next};

    // Result register: advance on accept, hold while the sink stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (accept) begin
            removed_reg   <= ctrl.remove_en ? cell_entry[0] : '0;
            front_reg     <= cell_valid_next[0] ? cell_entry_next[0] : '0;
            empty_reg     <= (count_next == '0);
            count_out_reg <= count_wide[spq_pkg::CountFieldWidth-1:0];
            status_reg    <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {status_reg, count_out_reg, empty_reg, front_reg, removed_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid bits disagree with entry count");

    a_error_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && status != spq_pkg::STATUS_OK |=> $stable(count_reg))
        else $error("rejected request changed the queue");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> empty_reg == (count_reg == '0))
        else $error("empty flag disagrees with entry count");

endmodule
